@@ hw/rtl/hcmm_pkg.sv @@
// Shared constants, operation codes and types of the handheld console memory map.
package hcmm_pkg;

    localparam int DATA_W = 8;
    localparam int ADDR_W = 16;
    localparam int FUNC_W = 2;

    // Operation codes of a request
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd2;

    // Address map
    localparam logic [ADDR_W-1:0] ROM_MASK  = 16'h7FFF;
    localparam logic [ADDR_W-1:0] BANK_MASK = 16'h1FFF;
    localparam logic [ADDR_W-1:0] WRAM_BASE = 16'hC000;
    localparam logic [ADDR_W-1:0] OAM_BASE  = 16'hFE00;
    localparam logic [ADDR_W-1:0] GAP_BASE  = 16'hFEA0;
    localparam logic [ADDR_W-1:0] IO_BASE   = 16'hFF00;
    localparam logic [ADDR_W-1:0] LY_ADDR   = 16'hFF44;

    localparam logic [DATA_W-1:0] OPEN_BUS  = 8'hFF;

    // Decoded access handed from the decoder to the top level
    typedef struct packed {
        logic              rd;
        logic              wr;
        logic              open_bus;
        logic [ADDR_W-1:0] mem_addr;
    } dec_t;

endpackage

@@ hw/rtl/hcmm_if.sv @@
// Request and response channel interfaces of the memory map.
interface hcmm_req_if;
    logic                          valid;
    logic                          ready;
    logic [hcmm_pkg::FUNC_W-1:0]   func;
    logic [hcmm_pkg::ADDR_W-1:0]   addr;
    logic [hcmm_pkg::DATA_W-1:0]   wdata;

    modport source (output valid, output func, output addr, output wdata, input ready);
    modport sink   (input valid, input func, input addr, input wdata, output ready);
endinterface

interface hcmm_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [hcmm_pkg::DATA_W-1:0]   rdata;

    modport source (output valid, output rdata, input ready);
    modport sink   (input valid, input rdata, output ready);
endinterface

@@ hw/rtl/hcmm_ram.sv @@
// Generic single-port-write, single-port-read synchronous RAM with registered read data.
module hcmm_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 16
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ hw/rtl/hcmm_decode.sv @@
// Bus address decoder: maps a request onto the flat storage address space.
module hcmm_decode (
    input  logic [hcmm_pkg::FUNC_W-1:0] func,
    input  logic [hcmm_pkg::ADDR_W-1:0] addr,
    output hcmm_pkg::dec_t              dec
);

    logic [3:0]                  top;
    logic                        ext_ram;
    logic                        gap;
    logic                        echo;
    logic                        no_write;
    logic [hcmm_pkg::ADDR_W-1:0] phys;

    always_comb
    begin
        top      = addr[15:12];
        ext_ram  = top inside {4'hA, 4'hB};
        gap      = (addr >= hcmm_pkg::GAP_BASE) && (addr < hcmm_pkg::IO_BASE);
        echo     = (top inside {[4'hE:4'hF]}) && (addr < hcmm_pkg::OAM_BASE);
        // echo area folds onto work RAM; everything else is stored at its bus address
        phys     = echo ? (hcmm_pkg::WRAM_BASE | (addr & hcmm_pkg::BANK_MASK)) : addr;
        no_write = !addr[15] || ext_ram || gap || (addr == hcmm_pkg::LY_ADDR);

        dec = '0;
        case (func)
            hcmm_pkg::FUNC_READ:
            begin
                dec.rd       = 1'b1;
                dec.open_bus = ext_ram || gap;
                dec.mem_addr = phys;
            end
            hcmm_pkg::FUNC_WRITE:
            begin
                dec.wr       = !no_write;
                dec.mem_addr = phys;
            end
            hcmm_pkg::FUNC_LOAD:
            begin
                dec.wr       = 1'b1;
                dec.mem_addr = addr & hcmm_pkg::ROM_MASK;
            end
            default:
            begin
                dec = '0;
            end
        endcase
    end

endmodule

@@ hw/rtl/handheld_console_memory_map.sv @@
// Handheld console memory map: decodes 16-bit bus requests (read, write, ROM image load)
// onto one 64K x 8 synchronous RAM that holds ROM, video RAM, work RAM, sprite RAM, I/O,
// high RAM and the interrupt enable byte at their bus addresses (the echo area folds onto
// work RAM). After reset the block runs a clearing pass over every RAM entry, one entry a
// cycle, and accepts no request until it ends. Afterwards it takes one request every clock
// while the response side keeps up; a read returns its byte through the RAM read register
// and the output register, which hold while the response stalls. External RAM and the
// unusable gap read as 0xFF; writes there, to ROM and to the scanline register are dropped.
module handheld_console_memory_map (
    input  logic          clk,
    input  logic          rst_n,
    hcmm_req_if.sink      req,
    hcmm_rsp_if.source    rsp
);

    hcmm_pkg::dec_t                dec;
    logic                          accept;
    logic                          p_moves;

    logic                          clearing_reg;
    logic [hcmm_pkg::ADDR_W-1:0]   clr_cnt_reg;
    logic                          p_valid_reg;
    logic                          p_open_reg;
    logic                          out_valid_reg;
    logic [hcmm_pkg::DATA_W-1:0]   out_data_reg;

    logic                          ram_we;
    logic [hcmm_pkg::ADDR_W-1:0]   ram_waddr;
    logic [hcmm_pkg::DATA_W-1:0]   ram_wdata;
    logic                          ram_re;
    logic [hcmm_pkg::DATA_W-1:0]   ram_rdata;

    hcmm_decode u_decode (
        .func (req.func),
        .addr (req.addr),
        .dec  (dec)
    );

    // read data stage can advance when the output register is free or being drained
    assign p_moves   = !out_valid_reg || rsp.ready;
    assign req.ready = !clearing_reg && (!p_valid_reg || p_moves);
    assign accept    = req.valid && req.ready;

    assign ram_we    = clearing_reg || (accept && dec.wr);
    assign ram_waddr = clearing_reg ? clr_cnt_reg : dec.mem_addr;
    assign ram_wdata = clearing_reg ? '0 : req.wdata;
    assign ram_re    = accept && dec.rd;

    hcmm_ram #(
        .DATA_W (hcmm_pkg::DATA_W),
        .ADDR_W (hcmm_pkg::ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (dec.mem_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
            p_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (&clr_cnt_reg)
                begin
                    clearing_reg <= 1'b0;
                end
            end

            if (ram_re)
            begin
                p_valid_reg <= 1'b1;
            end
            else if (p_moves)
            begin
                p_valid_reg <= 1'b0;
            end

            if (p_moves)
            begin
                out_valid_reg <= p_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ram_re)
        begin
            p_open_reg <= dec.open_bus;
        end
        if (p_moves && p_valid_reg)
        begin
            out_data_reg <= p_open_reg ? hcmm_pkg::OPEN_BUS : ram_rdata;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.rdata = out_data_reg;

endmodule
